// ===== src/q3k_pkg.sv =====
// Shared types and constants for the Q3_K superblock dequantizer.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package q3k_pkg;

    // Superblock byte layout.
    localparam int unsigned BLOCK_LEN = 110;
    localparam int unsigned OFF_QS    = 32;
    localparam int unsigned OFF_SC    = 96;
    localparam int unsigned OFF_D     = 108;
    localparam int unsigned NUM_SC    = 12;
    localparam int unsigned MEM_DEPTH = 96;
    localparam int unsigned MEM_AW    = 7;

    // Item function codes.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_DEQUANT = 1'b1;

    typedef struct packed {
        logic       func;
        logic [6:0] byte_offset;
        logic [7:0] byte_value;
        logic [7:0] element_index;
    } req_t;

    typedef struct packed {
        logic [31:0]       value_bits;
        logic signed [8:0] weight_int;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_NORM
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic calc_en;
        logic mul_en;
        logic out_load;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/q3k_block_dequantizer_unit.sv =====
// Top level of the Q3_K superblock dequantizer.
// Depends on q3k_pkg, q3k_ctrl and q3k_dp.
//
// Usage: the request channel (req_valid, req_stall, req) carries load and
// dequantize items. A load writes one byte of the 110-byte superblock and
// gives no result; a load beyond offset 109 is ignored. Loads are taken one
// per cycle while the controller is idle. A dequantize item returns one
// result item on the response channel (rsp_valid, rsp_stall, rsp) with the
// float32 weight bits and the 9-bit integer weight. It passes through fetch,
// scale decode, a multiply and float packing, sequenced through the controller
// states ST_FETCH, ST_MUL and ST_NORM, and the request channel stays stalled
// until the controller is back in ST_IDLE, so no new item is taken before the
// last dequantize is through. A result waiting in the output register does
// not stall requests unless a new result needs that register; then the
// packing stage holds until the receiver drops rsp_stall. Reset clears the
// controller and the output valid flag; the block bytes are undefined until
// loaded and must all be loaded before any element is read.
`default_nettype none

module q3k_block_dequantizer_unit
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire q3k_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output q3k_pkg::rsp_t      rsp
);
    import q3k_pkg::*;

    cmd_t cmd;

    q3k_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req.func),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    q3k_dp u_dp
    (
        .clk (clk),
        .cmd (cmd),
        .req (req),
        .rsp (rsp)
    );

endmodule

`default_nettype wire

// ===== src/q3k_ctrl.sv =====
// Controller state machine for the Q3_K dequantizer.
// Depends on q3k_pkg; sequences the datapath stages and owns both handshakes.
`default_nettype none

module q3k_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_func,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output q3k_pkg::cmd_t      cmd
);
    import q3k_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can be refilled when empty or being drained.
    assign out_free = !out_valid_reg || !rsp_stall;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_func == FUNC_DEQUANT)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_NORM;
            ST_NORM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Output and command logic.
    always_comb
    begin
        req_stall    = 1'b1;
        cmd.accept   = 1'b0;
        cmd.calc_en  = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_FETCH: cmd.calc_en = 1'b1;
            ST_MUL:   cmd.mul_en  = 1'b1;
            ST_NORM:  cmd.out_load = out_free;
            default:  req_stall = 1'b1;
        endcase
    end

    // The result valid flag follows loads and drains of the output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/q3k_dp.sv =====
// Datapath of the Q3_K dequantizer: block storage, scale decode, multiply, float pack.
// Depends on q3k_pkg; driven by commands from q3k_ctrl.
`default_nettype none

module q3k_dp
(
    input  wire logic          clk,
    input  wire q3k_pkg::cmd_t cmd,
    input  wire q3k_pkg::req_t req,
    output q3k_pkg::rsp_t      rsp
);
    import q3k_pkg::*;

    // Mask and quant bytes live in a memory; scales and the fp16 scale in registers.
    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  sc_reg [NUM_SC];
    logic [15:0] d_reg;

    logic [7:0]  mask_rd_reg;
    logic [7:0]  qs_rd_reg;
    logic        n_reg;
    logic [1:0]  j_reg;
    logic        lh_reg;

    logic [MEM_AW-1:0] qs_addr;
    logic [5:0]  sub [16];
    logic [3:0]  is_sel;
    logic signed [6:0] sc_c;
    logic signed [3:0] qc_c;
    logic [1:0]  q_c;
    logic        hb_c;
    logic signed [8:0] w_c;

    logic signed [8:0] w_reg;
    logic        sign_reg;
    logic [7:0]  mag_reg;
    logic        sign2_reg;
    logic        zero_reg;
    logic [18:0] prod_reg;
    logic [7:0]  base_reg;
    logic signed [8:0] w2_reg;
    rsp_t        out_reg;

    logic        hs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [10:0] mant;
    logic [4:0]  p_c;
    logic [41:0] shifted;
    logic [31:0] bits_c;

    assign hs = d_reg[15];
    assign he = d_reg[14:10];
    assign hm = d_reg[9:0];
    assign mant = (he == 5'd0) ? {1'b0, hm} : {1'b1, hm};

    assign qs_addr = MEM_AW'(OFF_QS) + {1'b0, req.element_index[7], req.element_index[4:0]};

    // Memory write on loads and registered reads on dequantize items.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (req.func == FUNC_LOAD)
            begin
                if (req.byte_offset < MEM_AW'(OFF_SC))
                begin
                    mem[req.byte_offset] <= req.byte_value;
                end
            end
            else
            begin
                mask_rd_reg <= mem[{2'b00, req.element_index[4:0]}];
                qs_rd_reg   <= mem[qs_addr];
            end
        end
    end

    // Scale and fp16 registers take their loads.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && req.func == FUNC_LOAD)
        begin
            for (int k = 0; k < NUM_SC; k++)
            begin
                if (req.byte_offset == MEM_AW'(OFF_SC + k))
                begin
                    sc_reg[k] <= req.byte_value;
                end
            end
            if (req.byte_offset == MEM_AW'(OFF_D))
            begin
                d_reg[7:0] <= req.byte_value;
            end
            if (req.byte_offset == MEM_AW'(OFF_D + 1))
            begin
                d_reg[15:8] <= req.byte_value;
            end
        end
    end

    // Element coordinates for the following stages.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            n_reg  <= req.element_index[7];
            j_reg  <= req.element_index[6:5];
            lh_reg <= req.element_index[4];
        end
    end

    // All sixteen 6-bit sub-block scales unpacked from fixed byte positions.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sub[k]      = {sc_reg[k + 8][1:0], sc_reg[k][3:0]};
            sub[k + 4]  = {sc_reg[k + 8][3:2], sc_reg[k + 4][3:0]};
            sub[k + 8]  = {sc_reg[k + 8][5:4], sc_reg[k][7:4]};
            sub[k + 12] = {sc_reg[k + 8][7:6], sc_reg[k + 4][7:4]};
        end
    end

    // Center the scale and quant and form the integer weight.
    assign is_sel = {n_reg, j_reg, lh_reg};
    assign sc_c   = $signed({1'b0, sub[is_sel]}) - 7'sd32;
    assign q_c    = 2'(qs_rd_reg >> {j_reg, 1'b0});
    assign hb_c   = mask_rd_reg[{n_reg, j_reg}];
    assign qc_c   = $signed({2'b00, q_c}) - (hb_c ? 4'sd0 : 4'sd4);
    assign w_c    = 9'(sc_c) * 9'(qc_c);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_en)
        begin
            w_reg    <= w_c;
            sign_reg <= hs ^ sc_c[6] ^ qc_c[3];
            mag_reg  <= w_c[8] ? 8'(-w_c) : w_c[7:0];
        end
    end

    // Mantissa times integer magnitude; exact in 19 bits.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg  <= 19'(mant) * 19'(mag_reg);
            zero_reg  <= (mag_reg == 8'd0);
            sign2_reg <= sign_reg;
            w2_reg    <= w_reg;
            base_reg  <= (he == 5'd0) ? 8'd103 : 8'({3'b000, he} + 8'd102);
        end
    end

    // Leading-one position of the product.
    always_comb
    begin
        p_c = 5'd0;
        for (int b = 1; b < 19; b++)
        begin
            if (prod_reg[b])
            begin
                p_c = 5'(b);
            end
        end
    end

    assign shifted = {23'd0, prod_reg} << (5'd23 - p_c);

    // Float32 packing with NaN, infinity and signed zero handling.
    always_comb
    begin
        if (he == 5'd31)
        begin
            if (hm != 10'd0)
            begin
                bits_c = {hs, 8'hFF, 1'b1, hm[8:0] , 13'd0} | {9'd0, hm[9], 22'd0};
            end
            else if (zero_reg)
            begin
                bits_c = 32'h7FC0_0000;
            end
            else
            begin
                bits_c = {sign2_reg, 8'hFF, 23'd0};
            end
        end
        else if (prod_reg == 19'd0)
        begin
            bits_c = {sign2_reg, 31'd0};
        end
        else
        begin
            bits_c = {sign2_reg, 8'(base_reg + {3'b000, p_c}), shifted[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.value_bits <= bits_c;
            out_reg.weight_int <= w2_reg;
        end
    end

    assign rsp = out_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the Q3_K superblock dequantizer top level.
// Depends on q3k_pkg and q3k_block_dequantizer_unit; predicts every result
// from a shadow copy of the superblock and checks it field by field.
`timescale 1ns / 100ps

module tb;
    import q3k_pkg::*;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    // Shadow of the superblock and the results still owed by the block.
    logic [7:0] shadow_bytes [0:BLOCK_LEN-1];
    rsp_t       owed_weights [$];
    int         mismatches = 0;
    bit         quiet = 1'b0;
    bit         rsp_fire = 1'b0;
    int         rsp_hold = 0;

    q3k_block_dequantizer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Decode one 6-bit sub-block scale from the twelve packed scale bytes.
    function automatic int unsigned decode_scale(input int unsigned is);
        int unsigned b;
        b = OFF_SC;
        if (is < 4)
            return (shadow_bytes[b + is] & 8'h0F) | ((shadow_bytes[b + is + 8] & 3) << 4);
        if (is < 8)
            return (shadow_bytes[b + is] & 8'h0F) |
                   (((shadow_bytes[b + is + 4] >> 2) & 3) << 4);
        if (is < 12)
            return (shadow_bytes[b + is - 8] >> 4) | (((shadow_bytes[b + is] >> 4) & 3) << 4);
        return (shadow_bytes[b + is - 8] >> 4) | (((shadow_bytes[b + is - 4] >> 6) & 3) << 4);
    endfunction

    // Exact float32 of an fp16 scale times two small integer factors.
    function automatic logic [31:0] scaled_f32(input logic [15:0] half, input int fa,
                                               input int fb);
        logic        sgn;
        logic [4:0]  hexp;
        logic [9:0]  hman;
        int unsigned mag;
        int unsigned prod;
        int          ex;
        int          msb;
        logic [31:0] frac;
        sgn  = half[15] ^ (fa < 0) ^ (fb < 0);
        hexp = half[14:10];
        hman = half[9:0];
        mag  = (fa < 0 ? -fa : fa) * (fb < 0 ? -fb : fb);
        if (hexp == 5'd31)
        begin
            // A NaN keeps its sign and payload with the quiet bit set.
            if (hman != 0)
                return {half[15], 8'hFF, 1'b1, hman[8:0], 13'd0};
            if (mag == 0)
                return 32'h7FC0_0000;
            return {sgn, 8'hFF, 23'd0};
        end
        if (hexp == 0)
        begin
            prod = hman * mag;
            ex   = -24;
        end
        else
        begin
            prod = {1'b1, hman} * mag;
            ex   = int'(hexp) - 25;
        end
        if (prod == 0)
            return {sgn, 31'd0};
        msb = 0;
        while (msb < 31 && (prod >> (msb + 1)) != 0)
            msb++;
        frac = prod << (23 - msb);
        return {sgn, 8'(msb + ex + 127), frac[22:0]};
    endfunction

    // Expected result of dequantizing one element of the shadow superblock.
    function automatic rsp_t dequant_expect(input logic [7:0] idx);
        int unsigned n;
        int unsigned j;
        int unsigned l;
        int unsigned q;
        int          sc;
        int          qc;
        rsp_t        r;
        n  = idx >> 7;
        j  = (idx >> 5) & 3;
        l  = idx & 31;
        sc = int'(decode_scale(8 * n + 2 * j + (l >> 4))) - 32;
        q  = (shadow_bytes[OFF_QS + 32 * n + l] >> (2 * j)) & 3;
        qc = int'(q) - (((shadow_bytes[l] >> (4 * n + j)) & 1) ? 0 : 4);
        r.weight_int = 9'(sc * qc);
        r.value_bits = scaled_f32({shadow_bytes[OFF_D + 1], shadow_bytes[OFF_D]}, sc, qc);
        return r;
    endfunction

    // Offer one item, wait for its acceptance, then update the prediction.
    task automatic send_item(input req_t item);
        int gap;
        bit taken;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        if (item.func == FUNC_LOAD)
        begin
            if (item.byte_offset < BLOCK_LEN)
                shadow_bytes[item.byte_offset] = item.byte_value;
        end
        else
        begin
            owed_weights.push_back(dequant_expect(item.element_index));
        end
    endtask

    task automatic load_byte(input int off, input logic [7:0] val);
        req_t item;
        item.func          = FUNC_LOAD;
        item.byte_offset   = 7'(off);
        item.byte_value    = val;
        item.element_index = 8'($urandom);
        send_item(item);
    endtask

    task automatic read_element(input logic [7:0] idx);
        req_t item;
        item.func          = FUNC_DEQUANT;
        item.byte_offset   = 7'($urandom);
        item.byte_value    = 8'($urandom);
        item.element_index = idx;
        send_item(item);
    endtask

    // Hold requests off until every owed result has come back.
    task automatic drain;
        req_valid <= 1'b0;
        wait (owed_weights.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // Fill the whole superblock in a shuffled order with random bytes and the given fp16 scale.
    task automatic load_random_block(input logic [15:0] scale_half);
        int order [BLOCK_LEN];
        for (int i = 0; i < BLOCK_LEN; i++)
            order[i] = i;
        order.shuffle();
        foreach (order[i])
        begin
            if ($urandom_range(0, 19) == 0)
                load_byte($urandom_range(BLOCK_LEN, 127), 8'($urandom));
            if (order[i] == OFF_D)
                load_byte(OFF_D, scale_half[7:0]);
            else if (order[i] == OFF_D + 1)
                load_byte(OFF_D + 1, scale_half[15:8]);
            else
                load_byte(order[i], 8'($urandom));
        end
    endtask

    // Extreme scales, the largest weight, and special fp16 scales (NaN, infinity, subnormal, negative zero, largest).
    task automatic test_directed;
        logic [15:0] halves [7];
        halves = '{16'h7E01, 16'hFD55, 16'h7C00, 16'hFC00, 16'h0001, 16'h8000, 16'h7BFF};
        for (int i = 0; i < BLOCK_LEN; i++)
            load_byte(i, 8'($urandom));
        // Sub-scale 0 centers to zero, 1 to +31, 2 to -32.
        load_byte(OFF_SC + 0, 8'h00);
        load_byte(OFF_SC + 8, 8'h02);
        load_byte(OFF_SC + 1, 8'h0F);
        load_byte(OFF_SC + 9, 8'h03);
        load_byte(OFF_SC + 2, 8'h00);
        load_byte(OFF_SC + 10, 8'h00);
        // Element 32 gets quant 0 with the high bit clear: weight 128.
        load_byte(0, 8'h00);
        load_byte(OFF_QS, 8'h00);
        load_byte(16, 8'h01);
        load_byte(OFF_QS + 16, 8'h03);
        load_byte(OFF_D, 8'h00);
        load_byte(OFF_D + 1, 8'h3C);
        load_byte(110, 8'hFF);
        load_byte(127, 8'hFF);
        read_element(8'd0);
        read_element(8'd16);
        read_element(8'd32);
        read_element(8'd127);
        read_element(8'd128);
        read_element(8'd255);
        foreach (halves[i])
        begin
            load_byte(OFF_D, halves[i][7:0]);
            load_byte(OFF_D + 1, halves[i][15:8]);
            read_element(8'd0);
            read_element(8'd32);
        end
        drain();
    endtask

    // Random blocks, each read at random elements with a few byte rewrites.
    task automatic test_random;
        logic [15:0] specials [6];
        logic [15:0] half;
        int          phase;
        specials = '{16'h7C00, 16'hFC00, 16'h7E00, 16'hFFFF, 16'h0000, 16'h03FF};
        phase = 0;
        while (phase < 3)
        begin
            quiet = (phase == 1);
            half  = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 5)]
                                                : 16'($urandom);
            load_random_block(half);
            repeat ($urandom_range(40, 120))
            begin
                if ($urandom_range(0, 15) == 0)
                    load_byte($urandom_range(0, 127), 8'($urandom));
                else
                    read_element(8'($urandom));
            end
            if (phase % 2 == 0)
                drain();
            phase++;
        end
        quiet = 1'b0;
        drain();
    endtask

    // Receiver: a random stall after each taken result, none in quiet phases.
    always @(posedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold  <= rsp_hold - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (rsp_fire && !quiet)
                rsp_hold <= $urandom_range(0, 7);
        end
    end

    // Compare each result taken at the coming edge with the oldest one owed.
    always @(negedge clk)
    begin
        rsp_t want;
        rsp_fire = rst_n && rsp_valid && !rsp_stall;
        if (rsp_fire)
        begin
            if (owed_weights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value_bits=%h weight_int=%0d",
                             rsp.value_bits, rsp.weight_int);
            end
            else
            begin
                want = owed_weights.pop_front();
                if (rsp.value_bits !== want.value_bits ||
                    rsp.weight_int !== want.weight_int)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d, got %h/%0d",
                                 want.value_bits, want.weight_int,
                                 rsp.value_bits, rsp.weight_int);
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && owed_weights.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
